// ===== src/ogpf_pkg.sv =====
// Shared constants, codes and types of the occupancy grid point filter.
package ogpf_pkg;

    // Map store and grid geometry.
    localparam int MAP_CELLS = 1048576;
    localparam int MAX_SIDE  = 4096;
    localparam int ADDR_W    = $clog2(MAP_CELLS);
    localparam int SIDE_W    = $clog2(MAX_SIDE);
    localparam int DIM_W     = SIDE_W + 1;
    localparam int IDX_W     = SIDE_W + DIM_W;
    localparam int CMP_W     = 33;

    // Fixed field widths.
    localparam int COORD_W  = 32;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int CPM_W    = 32;
    localparam int HALF_W   = CPM_W / 2;
    localparam int PP_W     = DIFF_W + HALF_W;
    localparam int SUM_W    = PP_W + 1;
    localparam int GRID_W   = 13;
    localparam int OCC_W    = 8;
    localparam int WIDX_W   = 20;
    localparam int CELL_W   = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values.
    localparam logic [CPM_W-1:0]  CPM_RESET       = 32'd1310720;
    localparam logic [GRID_W-1:0] GRID_SIDE_RESET = 13'd1024;
    localparam logic [OCC_W-1:0]  THRESHOLD_RESET = 8'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_LOADED      = 3'd0,
        REG_ORIGIN_X        = 3'd1,
        REG_ORIGIN_Y        = 3'd2,
        REG_CELLS_PER_METRE = 3'd3,
        REG_GRID_WIDTH      = 3'd4,
        REG_GRID_HEIGHT     = 3'd5,
        REG_FREE_THRESHOLD  = 3'd6
    } t_cfg_reg;

    typedef enum logic {
        OP_CLASSIFY = 1'b0,
        OP_WRITE    = 1'b1
    } t_opcode;

    typedef struct packed {
        logic                       map_loaded;
        logic signed [COORD_W-1:0]  origin_x;
        logic signed [COORD_W-1:0]  origin_y;
        logic [CPM_W-1:0]           cells_per_metre;
        logic [GRID_W-1:0]          grid_width;
        logic [GRID_W-1:0]          grid_height;
        logic signed [OCC_W-1:0]    free_threshold;
    } t_cfg;

    // Stage load enables and the write strobe for the map store.
    typedef struct packed {
        logic en_s1;
        logic en_s2;
        logic en_s3;
        logic en_s4;
        logic en_s5;
        logic s4_write;
    } t_pipe_ctl;

    // Cell coordinates leaving the cell calculation.
    typedef struct packed {
        logic              coord_ok;
        logic [SIDE_W-1:0] col;
        logic [SIDE_W-1:0] row;
        logic [WIDX_W-1:0] write_index;
        logic [OCC_W-1:0]  write_value;
    } t_cell;

    // Map lookup result.
    typedef struct packed {
        logic                    in_map;
        logic [IDX_W-1:0]        idx;
        logic signed [OCC_W-1:0] occupancy;
    } t_lookup;

    // Grid side limited to the largest supported side.
    function automatic logic [DIM_W-1:0] clamp_side(input logic [GRID_W-1:0] side);
        logic [DIM_W-1:0] res;
        if (32'(side) > 32'(MAX_SIDE)) begin
            res = DIM_W'(MAX_SIDE);
        end else begin
            res = DIM_W'(side);
        end
        return res;
    endfunction

endpackage

// ===== src/ogpf_if.sv =====
// Channel interfaces of the occupancy grid point filter: input, result and configuration.
interface ogpf_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   opcode;
    logic signed [ogpf_pkg::COORD_W-1:0]    point_x;
    logic signed [ogpf_pkg::COORD_W-1:0]    point_y;
    logic [ogpf_pkg::WIDX_W-1:0]            write_index;
    logic signed [ogpf_pkg::OCC_W-1:0]      write_value;

    modport source (output valid, opcode, point_x, point_y, write_index, write_value,
                    input ready);
    modport sink (input valid, opcode, point_x, point_y, write_index, write_value,
                  output ready);
endinterface

interface ogpf_out_if;
    logic                               valid;
    logic                               ready;
    logic                               point_kept;
    logic                               inside_map;
    logic [ogpf_pkg::CELL_W-1:0]        cell_index;
    logic signed [ogpf_pkg::OCC_W-1:0]  occupancy;

    modport source (output valid, point_kept, inside_map, cell_index, occupancy,
                    input ready);
    modport sink (input valid, point_kept, inside_map, cell_index, occupancy,
                  output ready);
endinterface

interface ogpf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ogpf_pkg::CFG_IDX_W-1:0]     index;
    logic [ogpf_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ogpf_cfg_regs.sv =====
// Configuration register file of the occupancy grid point filter.
module ogpf_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ogpf_cfg_if.sink            i_cfg,
    output ogpf_pkg::t_cfg      o_cfg
);

    ogpf_pkg::t_cfg r_cfg;
    ogpf_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (ogpf_pkg::t_cfg_reg'(i_cfg.index))
                ogpf_pkg::REG_MAP_LOADED: begin
                    n_cfg.map_loaded = i_cfg.data[0];
                end
                ogpf_pkg::REG_ORIGIN_X: begin
                    n_cfg.origin_x = $signed(i_cfg.data[ogpf_pkg::COORD_W-1:0]);
                end
                ogpf_pkg::REG_ORIGIN_Y: begin
                    n_cfg.origin_y = $signed(i_cfg.data[ogpf_pkg::COORD_W-1:0]);
                end
                ogpf_pkg::REG_CELLS_PER_METRE: begin
                    n_cfg.cells_per_metre = i_cfg.data[ogpf_pkg::CPM_W-1:0];
                end
                ogpf_pkg::REG_GRID_WIDTH: begin
                    n_cfg.grid_width = i_cfg.data[ogpf_pkg::GRID_W-1:0];
                end
                ogpf_pkg::REG_GRID_HEIGHT: begin
                    n_cfg.grid_height = i_cfg.data[ogpf_pkg::GRID_W-1:0];
                end
                ogpf_pkg::REG_FREE_THRESHOLD: begin
                    n_cfg.free_threshold = $signed(i_cfg.data[ogpf_pkg::OCC_W-1:0]);
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_loaded      <= 1'b0;
            r_cfg.origin_x        <= '0;
            r_cfg.origin_y        <= '0;
            r_cfg.cells_per_metre <= ogpf_pkg::CPM_RESET;
            r_cfg.grid_width      <= ogpf_pkg::GRID_SIDE_RESET;
            r_cfg.grid_height     <= ogpf_pkg::GRID_SIDE_RESET;
            r_cfg.free_threshold  <= $signed(ogpf_pkg::THRESHOLD_RESET);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/ogpf_cell_calc.sv =====
// Three-stage cell coordinate calculation for x and y lanes.
module ogpf_cell_calc (
    input  logic                                i_clk,
    input  ogpf_pkg::t_pipe_ctl                 i_ctl,
    input  ogpf_pkg::t_cfg                      i_cfg,
    input  logic signed [ogpf_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [ogpf_pkg::COORD_W-1:0] i_point_y,
    input  logic [ogpf_pkg::WIDX_W-1:0]         i_write_index,
    input  logic [ogpf_pkg::OCC_W-1:0]          i_write_value,
    output ogpf_pkg::t_cell                     o_cell
);

    // Lane 0 is x, lane 1 is y.
    logic signed [ogpf_pkg::COORD_W-1:0] w_pt   [2];
    logic signed [ogpf_pkg::COORD_W-1:0] w_org  [2];
    logic signed [ogpf_pkg::DIFF_W-1:0]  w_diff [2];
    logic [ogpf_pkg::SUM_W-1:0]          w_sum  [2];
    logic [ogpf_pkg::CPM_W-1:0]          w_c    [2];
    logic [1:0]                          w_ok;
    logic [ogpf_pkg::DIM_W-1:0]          w_side [2];

    // Stage 1: magnitude of the offset from the origin.
    logic [ogpf_pkg::DIFF_W-1:0] r_s1_mag [2];
    logic [1:0]                  r_s1_neg;
    logic [ogpf_pkg::WIDX_W-1:0] r_s1_widx;
    logic [ogpf_pkg::OCC_W-1:0]  r_s1_wval;

    // Stage 2: partial products with the two halves of the inverse resolution.
    logic [ogpf_pkg::PP_W-1:0]   r_s2_plo [2];
    logic [ogpf_pkg::PP_W-1:0]   r_s2_phi [2];
    logic [1:0]                  r_s2_neg;
    logic [ogpf_pkg::WIDX_W-1:0] r_s2_widx;
    logic [ogpf_pkg::OCC_W-1:0]  r_s2_wval;

    // Stage 3: truncated cells and range check.
    ogpf_pkg::t_cell r_s3;

    assign w_pt[0]   = i_point_x;
    assign w_pt[1]   = i_point_y;
    assign w_org[0]  = i_cfg.origin_x;
    assign w_org[1]  = i_cfg.origin_y;
    assign w_side[0] = ogpf_pkg::clamp_side(i_cfg.grid_width);
    assign w_side[1] = ogpf_pkg::clamp_side(i_cfg.grid_height);

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_diff[l] = ogpf_pkg::DIFF_W'(w_pt[l]) - ogpf_pkg::DIFF_W'(w_org[l]);
            // Product shifted right by 32 is (hi + lo >> 16) >> 16.
            w_sum[l]  = ogpf_pkg::SUM_W'(r_s2_phi[l])
                      + ogpf_pkg::SUM_W'(r_s2_plo[l][ogpf_pkg::PP_W-1:ogpf_pkg::HALF_W]);
            w_c[l]    = w_sum[l][ogpf_pkg::HALF_W +: ogpf_pkg::CPM_W];
            // A negative offset of less than one cell truncates to cell 0.
            w_ok[l]   = !(r_s2_neg[l] && (w_c[l] != '0))
                      && (32'(w_c[l]) < 32'(w_side[l]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s1) begin
            for (int l = 0; l < 2; l++) begin
                r_s1_neg[l] <= w_diff[l][ogpf_pkg::DIFF_W-1];
                r_s1_mag[l] <= w_diff[l][ogpf_pkg::DIFF_W-1] ? (~w_diff[l] + 1'b1)
                                                             : w_diff[l];
            end
            r_s1_widx <= i_write_index;
            r_s1_wval <= i_write_value;
        end
        if (i_ctl.en_s2) begin
            for (int l = 0; l < 2; l++) begin
                r_s2_plo[l] <= ogpf_pkg::PP_W'(r_s1_mag[l])
                             * ogpf_pkg::PP_W'(i_cfg.cells_per_metre[ogpf_pkg::HALF_W-1:0]);
                r_s2_phi[l] <= ogpf_pkg::PP_W'(r_s1_mag[l])
                             * ogpf_pkg::PP_W'(i_cfg.cells_per_metre[ogpf_pkg::CPM_W-1:
                                                                      ogpf_pkg::HALF_W]);
            end
            r_s2_neg  <= r_s1_neg;
            r_s2_widx <= r_s1_widx;
            r_s2_wval <= r_s1_wval;
        end
        if (i_ctl.en_s3) begin
            r_s3.coord_ok    <= &w_ok;
            r_s3.col         <= ogpf_pkg::SIDE_W'(w_c[0]);
            r_s3.row         <= ogpf_pkg::SIDE_W'(w_c[1]);
            r_s3.write_index <= r_s2_widx;
            r_s3.write_value <= r_s2_wval;
        end
    end

    assign o_cell = r_s3;

endmodule

// ===== src/ogpf_grid_map.sv =====
// Cell index calculation and the occupancy map store.
module ogpf_grid_map (
    input  logic                i_clk,
    input  ogpf_pkg::t_pipe_ctl i_ctl,
    input  ogpf_pkg::t_cfg      i_cfg,
    input  ogpf_pkg::t_cell     i_cell,
    output ogpf_pkg::t_lookup   o_lookup
);

    logic [ogpf_pkg::DIM_W-1:0]  w_width;
    logic                        w_inside;
    logic                        w_wr_en;
    logic [ogpf_pkg::ADDR_W-1:0] w_addr;

    // Stage 4: row * width + column.
    logic                        r_s4_ok;
    logic [ogpf_pkg::IDX_W-1:0]  r_s4_idx;
    logic [ogpf_pkg::WIDX_W-1:0] r_s4_widx;
    logic [ogpf_pkg::OCC_W-1:0]  r_s4_wval;

    // Stage 5: store access.
    logic                        r_s5_inside;
    logic [ogpf_pkg::IDX_W-1:0]  r_s5_idx;
    logic [ogpf_pkg::OCC_W-1:0]  r_rdata;
    logic [ogpf_pkg::OCC_W-1:0]  r_mem [ogpf_pkg::MAP_CELLS];

    assign w_width  = ogpf_pkg::clamp_side(i_cfg.grid_width);
    assign w_inside = r_s4_ok
                   && (ogpf_pkg::CMP_W'(r_s4_idx) < ogpf_pkg::CMP_W'(ogpf_pkg::MAP_CELLS));
    // Writes beyond the store are dropped.
    assign w_wr_en  = i_ctl.s4_write
                   && (ogpf_pkg::CMP_W'(r_s4_widx) < ogpf_pkg::CMP_W'(ogpf_pkg::MAP_CELLS));
    assign w_addr   = i_ctl.s4_write ? ogpf_pkg::ADDR_W'(r_s4_widx)
                                     : ogpf_pkg::ADDR_W'(r_s4_idx);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s4) begin
            r_s4_ok   <= i_cell.coord_ok;
            r_s4_idx  <= ogpf_pkg::IDX_W'(ogpf_pkg::IDX_W'(i_cell.row)
                                          * ogpf_pkg::IDX_W'(w_width))
                       + ogpf_pkg::IDX_W'(i_cell.col);
            r_s4_widx <= i_cell.write_index;
            r_s4_wval <= i_cell.write_value;
        end
        if (i_ctl.en_s5) begin
            r_s5_inside <= w_inside;
            r_s5_idx    <= r_s4_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s5) begin
            if (w_wr_en) begin
                r_mem[w_addr] <= r_s4_wval;
            end
            r_rdata <= r_mem[w_addr];
        end
    end

    assign o_lookup.in_map    = r_s5_inside;
    assign o_lookup.idx       = r_s5_idx;
    assign o_lookup.occupancy = $signed(r_rdata);

endmodule

// ===== src/occupancy_grid_point_filter_core.sv =====
// Top level of the occupancy grid point filter: handshake control and result register.
//
// Words enter on i_in (valid/ready). A classify word (opcode 0) carries a point in
// Q16.16 metres and yields one result word on o_out; a write word (opcode 1) stores
// write_value into map cell write_index and yields nothing. Configuration registers
// are written on i_cfg, which is always ready; the user must write them only while
// no word is in flight, as the block does not enforce it. The datapath is six
// register stages: offset magnitude, partial products, cell truncation and range
// check, index multiply, map store access, result register. One word is accepted
// every cycle while the receiver takes results. Each stage has its own valid bit
// and takes a new word whenever it is empty or its successor moves, so bubbles
// close up and a stalled receiver fills the stages before i_in.ready falls.
// Nothing is lost or repeated under stalls. Reset clears all valid bits and the
// configuration registers; the map store (one read/write port, one access per
// cycle) is not cleared and holds undefined values until written.
module occupancy_grid_point_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ogpf_in_if.sink     i_in,
    ogpf_out_if.source  o_out,
    ogpf_cfg_if.sink    i_cfg
);

    ogpf_pkg::t_cfg      w_cfg;
    ogpf_pkg::t_pipe_ctl w_ctl;
    ogpf_pkg::t_cell     w_cell;
    ogpf_pkg::t_lookup   w_lookup;
    logic [6:1]          w_adv;
    logic                w_keep;

    logic [6:1]          r_vld;
    logic [4:1]          r_cls;

    logic                          r_kept;
    logic                          r_inside;
    logic [ogpf_pkg::CELL_W-1:0]   r_cell_index;
    logic signed [ogpf_pkg::OCC_W-1:0] r_occ;

    // A stage advances when it is empty or the next stage advances.
    always_comb begin
        w_adv[6] = !r_vld[6] || o_out.ready;
        for (int s = 5; s >= 1; s--) begin
            w_adv[s] = !r_vld[s] || w_adv[s+1];
        end
    end

    assign i_in.ready     = w_adv[1];
    assign w_ctl.en_s1    = w_adv[1];
    assign w_ctl.en_s2    = w_adv[2];
    assign w_ctl.en_s3    = w_adv[3];
    assign w_ctl.en_s4    = w_adv[4];
    assign w_ctl.en_s5    = w_adv[5];
    assign w_ctl.s4_write = r_vld[4] && !r_cls[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cls <= '0;
        end else begin
            if (w_adv[1]) begin
                r_vld[1] <= i_in.valid;
                r_cls[1] <= (ogpf_pkg::t_opcode'(i_in.opcode) == ogpf_pkg::OP_CLASSIFY);
            end
            for (int s = 2; s <= 4; s++) begin
                if (w_adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                    r_cls[s] <= r_cls[s-1];
                end
            end
            // Write words end at the store access.
            if (w_adv[5]) begin
                r_vld[5] <= r_vld[4] && r_cls[4];
            end
            if (w_adv[6]) begin
                r_vld[6] <= r_vld[5];
            end
        end
    end

    ogpf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ogpf_cell_calc u_cell_calc (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .i_cfg         (w_cfg),
        .i_point_x     (i_in.point_x),
        .i_point_y     (i_in.point_y),
        .i_write_index (i_in.write_index),
        .i_write_value (i_in.write_value),
        .o_cell        (w_cell)
    );

    ogpf_grid_map u_grid_map (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_cfg    (w_cfg),
        .i_cell   (w_cell),
        .o_lookup (w_lookup)
    );

    // With no map loaded every point is kept and the cell fields read as zero.
    assign w_keep = !w_cfg.map_loaded
                 || (w_lookup.in_map && (w_lookup.occupancy < w_cfg.free_threshold));

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_kept       <= w_keep;
            r_inside     <= w_cfg.map_loaded && w_lookup.in_map;
            r_cell_index <= (w_cfg.map_loaded && w_lookup.in_map)
                          ? ogpf_pkg::CELL_W'(w_lookup.idx) : '0;
            r_occ        <= (w_cfg.map_loaded && w_lookup.in_map) ? w_lookup.occupancy : '0;
        end
    end

    assign o_out.valid      = r_vld[6];
    assign o_out.point_kept = r_kept;
    assign o_out.inside_map = r_inside;
    assign o_out.cell_index = r_cell_index;
    assign o_out.occupancy  = r_occ;

endmodule

// ===== src/ogpf_checker.sv =====
// Port-level checks of the occupancy grid point filter, bound to the top level.
module ogpf_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic                                 i_point_kept,
    input logic                                 i_inside_map,
    input logic [ogpf_pkg::CELL_W-1:0]          i_cell_index,
    input logic signed [ogpf_pkg::OCC_W-1:0]    i_occupancy
);

    // A result word stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before it was taken");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_point_kept) && $stable(i_inside_map)
            && $stable(i_cell_index) && $stable(i_occupancy))
        else $error("stalled result word changed");

    // Reset empties the pipeline, so no result is offered right after it.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // A point outside the map reports zero index and occupancy.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_inside_map |-> (i_cell_index == '0) && (i_occupancy == '0))
        else $error("outside point carries cell data");

endmodule

bind occupancy_grid_point_filter_core ogpf_checker u_ogpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_point_kept (o_out.point_kept),
    .i_inside_map (o_out.inside_map),
    .i_cell_index (o_out.cell_index),
    .i_occupancy  (o_out.occupancy)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the occupancy grid point filter: directed and random words.
package ogpf_tb_pkg;
    import ogpf_pkg::*;

    typedef struct {
        t_opcode                  op;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [WIDX_W-1:0]         widx;
        logic signed [OCC_W-1:0]   wval;
    } point_word_t;

    typedef struct {
        logic                    kept;
        logic                    in_map;
        logic [CELL_W-1:0]       cell_idx;
        logic signed [OCC_W-1:0] occ;
    } verdict_t;

    // Mirrors the filter registers and the written part of the map store.
    class point_scoreboard;
        logic                      map_loaded;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [CPM_W-1:0]          cpm;
        logic [GRID_W-1:0]         grid_width;
        logic [GRID_W-1:0]         grid_height;
        logic signed [OCC_W-1:0]   threshold;
        logic signed [OCC_W-1:0]   map_mirror [int];
        verdict_t                  pending_verdicts [$];
        int                        failures;

        function new();
            map_loaded  = 1'b0;
            origin_x    = '0;
            origin_y    = '0;
            cpm         = CPM_RESET;
            grid_width  = GRID_SIDE_RESET;
            grid_height = GRID_SIDE_RESET;
            threshold   = THRESHOLD_RESET;
            failures    = 0;
        endfunction

        function void set_reg(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
            case (r)
                REG_MAP_LOADED:      map_loaded  = v[0];
                REG_ORIGIN_X:        origin_x    = v;
                REG_ORIGIN_Y:        origin_y    = v;
                REG_CELLS_PER_METRE: cpm         = v;
                REG_GRID_WIDTH:      grid_width  = v[GRID_W-1:0];
                REG_GRID_HEIGHT:     grid_height = v[GRID_W-1:0];
                REG_FREE_THRESHOLD:  threshold   = v[OCC_W-1:0];
                default: ;
            endcase
        endfunction

        // Sides above the supported maximum behave as the maximum.
        function int side(logic [GRID_W-1:0] s);
            return (s > GRID_W'(MAX_SIDE)) ? MAX_SIDE : int'(s);
        endfunction

        // Cell along one axis, truncated toward zero; neg marks a cell below zero.
        function logic [63:0] axis_cell(logic signed [COORD_W-1:0] p,
                                        logic signed [COORD_W-1:0] o, output logic neg);
            longint      d;
            logic [63:0] mag;
            logic [63:0] c;
            d   = longint'(p) - longint'(o);
            mag = (d < 0) ? 64'(-d) : 64'(d);
            c   = (mag * 64'(cpm)) >> 32;
            neg = (d < 0) && (c != 0);
            return c;
        endfunction

        function void locate(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                             output logic in_map, output int idx);
            logic        nx;
            logic        ny;
            logic [63:0] col;
            logic [63:0] row;
            logic [63:0] w;
            logic [63:0] h;
            logic [63:0] flat;
            in_map = 1'b0;
            idx    = 0;
            if (map_loaded) begin
                w   = 64'(side(grid_width));
                h   = 64'(side(grid_height));
                col = axis_cell(px, origin_x, nx);
                row = axis_cell(py, origin_y, ny);
                if (!nx && !ny && col < w && row < h) begin
                    flat = row * w + col;
                    // Cells past the end of the store count as off the map.
                    if (flat < 64'(MAP_CELLS)) begin
                        in_map = 1'b1;
                        idx    = int'(flat);
                    end
                end
            end
        endfunction

        function void note_word(point_word_t w);
            verdict_t v;
            logic     in_map;
            int       idx;
            if (w.op == OP_WRITE) begin
                map_mirror[int'(w.widx)] = w.wval;
            end else begin
                locate(w.px, w.py, in_map, idx);
                v.in_map   = in_map;
                v.cell_idx = in_map ? CELL_W'(idx) : '0;
                v.occ      = in_map ? map_mirror[idx] : '0;
                v.kept     = !map_loaded || (in_map && v.occ < threshold);
                pending_verdicts.insert(pending_verdicts.size(), v);
            end
        endfunction

        function void mismatch(string field, logic signed [31:0] want,
                               logic signed [31:0] got);
            failures++;
            $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (pending_verdicts.size() == 0) begin
                failures++;
                $error("result word with no point waiting: point_kept=%0b cell_index=%0d",
                       got.kept, got.cell_idx);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.kept !== want.kept)     mismatch("point_kept", want.kept, got.kept);
                if (got.in_map !== want.in_map) mismatch("inside_map", want.in_map, got.in_map);
                if (got.cell_idx !== want.cell_idx)
                    mismatch("cell_index", want.cell_idx, got.cell_idx);
                if (got.occ !== want.occ)       mismatch("occupancy", want.occ, got.occ);
            end
        endfunction
    endclass
endpackage

module tb_top;
    import ogpf_pkg::*;
    import ogpf_tb_pkg::*;

    localparam int IDLE_PERCENT    = 7;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 185;
    localparam int CALM_PHASE      = 5;

    logic i_clk;
    logic i_rst_n;
    bit   calm;

    ogpf_in_if  in_ch ();
    ogpf_out_if out_ch ();
    ogpf_cfg_if cfg_ch ();

    point_scoreboard scoreboard = new();

    occupancy_grid_point_filter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check every accepted word, then stall at random.
    initial begin
        verdict_t got;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.kept     = out_ch.point_kept;
                got.in_map   = out_ch.inside_map;
                got.cell_idx = out_ch.cell_index;
                got.occ      = out_ch.occupancy;
                scoreboard.check_verdict(got);
            end
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    function automatic point_word_t random_word();
        point_word_t w;
        w.op   = t_opcode'($urandom_range(1));
        w.px   = $urandom;
        w.py   = $urandom;
        w.widx = WIDX_W'($urandom);
        w.wval = OCC_W'($urandom);
        return w;
    endfunction

    function automatic logic signed [OCC_W-1:0] random_occ();
        if ($urandom_range(99) < 70) return OCC_W'(int'($urandom_range(101)) - 1);
        return OCC_W'($urandom);
    endfunction

    // Coordinate whose offset from the origin lands at cell_q8 / 256 cells.
    function automatic logic signed [COORD_W-1:0] coord_for(logic signed [COORD_W-1:0] origin,
                                                           longint cell_q8);
        logic [63:0] mag;
        longint      p;
        if (scoreboard.cpm == 0) return $urandom;
        mag = (cell_q8 < 0) ? 64'(-cell_q8) : 64'(cell_q8);
        mag = ((mag << 24) + 64'(scoreboard.cpm) - 1) / 64'(scoreboard.cpm);
        p   = longint'(origin) + ((cell_q8 < 0) ? -longint'(mag) : longint'(mag));
        if (p != longint'(int'(p))) return $urandom;
        return COORD_W'(p);
    endfunction

    // Cell c with a random fraction; at or below zero the fraction may point downward.
    function automatic longint axis_q8(int c);
        longint frac;
        frac = $urandom_range(255);
        if (c <= 0 && $urandom_range(1) == 1) return longint'(c) * 256 - frac;
        return longint'(c) * 256 + frac;
    endfunction

    function automatic int rim_cell(int side);
        case ($urandom_range(3))
            0:       return -1;
            1:       return 0;
            2:       return side - 1;
            default: return side;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_side();
        if ($urandom_range(99) < 60) return $urandom_range(64, 1);
        return $urandom_range(MAX_SIDE, 1);
    endfunction

    task automatic send_word(point_word_t w);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= w.op;
        in_ch.point_x     <= w.px;
        in_ch.point_y     <= w.py;
        in_ch.write_index <= w.widx;
        in_ch.write_value <= w.wval;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        scoreboard.note_word(w);
    endtask

    task automatic send_write(logic [WIDX_W-1:0] idx, logic signed [OCC_W-1:0] val);
        point_word_t w;
        w      = random_word();
        w.op   = OP_WRITE;
        w.widx = idx;
        w.wval = val;
        send_word(w);
    endtask

    // A point on a cell nobody wrote yet gets that cell written first.
    task automatic send_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
        point_word_t w;
        logic        in_map;
        int          idx;
        scoreboard.locate(px, py, in_map, idx);
        if (in_map && !scoreboard.map_mirror.exists(idx)) send_write(WIDX_W'(idx), random_occ());
        w    = random_word();
        w.op = OP_CLASSIFY;
        w.px = px;
        w.py = py;
        send_word(w);
    endtask

    task automatic send_cell(longint cx_q8, longint cy_q8);
        send_point(coord_for(scoreboard.origin_x, cx_q8), coord_for(scoreboard.origin_y, cy_q8));
    endtask

    task automatic send_random_point();
        int w;
        int h;
        int pick;
        int cx;
        int cy;
        w    = scoreboard.side(scoreboard.grid_width);
        h    = scoreboard.side(scoreboard.grid_height);
        pick = $urandom_range(99);
        if (pick < 20) begin
            send_point($urandom, $urandom);
        end else begin
            if (pick < 55) begin
                cx = $urandom_range(7);
                cy = $urandom_range(7);
            end else if (pick < 85) begin
                cx = int'($urandom_range(w + 3)) - 2;
                cy = int'($urandom_range(h + 3)) - 2;
            end else begin
                cx = rim_cell(w);
                cy = rim_cell(h);
            end
            send_cell(axis_q8(cx), axis_q8(cy));
        end
    endtask

    task automatic send_random_write();
        int                w;
        int                pick;
        logic [WIDX_W-1:0] idx;
        w    = scoreboard.side(scoreboard.grid_width);
        pick = $urandom_range(99);
        if (pick < 50) begin
            idx = WIDX_W'($urandom_range(7) * w + $urandom_range(7));
        end else if (pick < 80) begin
            idx = WIDX_W'($urandom);
        end else begin
            idx = WIDX_W'($urandom_range(w * scoreboard.side(scoreboard.grid_height)));
        end
        send_write(idx, random_occ());
    endtask

    // Writes give no result, so the wait goes on past the last result to let trailing writes finish.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (scoreboard.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        scoreboard.set_reg(r, v);
    endtask

    task automatic configure_phase(int k);
        logic [CFG_DATA_W-1:0] loaded;
        logic [CFG_DATA_W-1:0] ox;
        logic [CFG_DATA_W-1:0] oy;
        logic [CFG_DATA_W-1:0] cpm;
        logic [CFG_DATA_W-1:0] gw;
        logic [CFG_DATA_W-1:0] gh;
        logic [CFG_DATA_W-1:0] thr;
        // Bits above each register's width are random and must be ignored.
        loaded = $urandom | 32'd1;
        ox     = $urandom_range(1 << 25) - (1 << 24);
        oy     = $urandom_range(1 << 25) - (1 << 24);
        cpm    = $urandom_range(1 << 21, 1 << 15);
        gw     = ($urandom & ~32'h1fff) | random_side();
        gh     = ($urandom & ~32'h1fff) | random_side();
        thr    = ($urandom & ~32'hff) | 32'(OCC_W'(int'($urandom_range(102)) - 1));
        case (k)
            1: loaded = loaded & ~32'd1;
            2: begin
                ox  = 32'h8000_0000;
                oy  = 32'h7fff_ffff;
                cpm = 32'hffff_ffff;
            end
            3: begin
                cpm = 32'd0;
                thr = 32'd127;
            end
            4: begin
                gw = 32'd0;
                gh = 32'd8191;
            end
            6: begin
                gw  = 32'd1;
                gh  = 32'd1;
                thr = 32'hffff_ff80;
            end
            7: begin
                ox  = 32'd0;
                oy  = 32'd0;
                cpm = 32'd65536;
                gw  = 32'd4096;
                gh  = 32'd4096;
            end
            8: begin
                gw = 32'd8191;
                gh = 32'd5000;
            end
            default: ;
        endcase
        cfg_write(REG_MAP_LOADED, loaded);
        cfg_write(REG_ORIGIN_X, ox);
        cfg_write(REG_ORIGIN_Y, oy);
        cfg_write(REG_CELLS_PER_METRE, cpm);
        cfg_write(REG_GRID_WIDTH, gw);
        cfg_write(REG_GRID_HEIGHT, gh);
        cfg_write(REG_FREE_THRESHOLD, thr);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OP_CLASSIFY;
        in_ch.point_x     <= '0;
        in_ch.point_y     <= '0;
        in_ch.write_index <= '0;
        in_ch.write_value <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_MAP_LOADED;
        cfg_ch.data       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // No map after reset: every point is kept and reports nothing else.
        send_point(32'sh7fff_ffff, 32'sh8000_0000);
        send_write('0, -8'sd128);
        send_point(32'sh8000_0000, 32'sh7fff_ffff);
        wait_drained();

        // Map on, all other registers at their reset values.
        cfg_write(REG_MAP_LOADED, 32'd1);
        cfg_ch.valid <= 1'b0;
        send_write(20'd0, -8'sd1);
        send_write(20'd1, 8'sd29);
        send_write(20'd2, 8'sd30);
        send_write(20'd3, 8'sd127);
        send_write(20'd4, -8'sd128);
        send_write(20'd1024, 8'sd100);
        send_write(20'hfffff, 8'sd0);
        send_cell(0, 0);
        send_cell(-128, 64);
        send_cell(-256, 0);
        send_cell(256, 0);
        send_cell(512, 0);
        send_cell(768, 0);
        send_cell(1024, 0);
        send_cell(0, 256);
        send_cell(1023 * 256 + 255, 1023 * 256 + 255);
        send_cell(1024 * 256, 0);
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        wait_drained();

        // Oversized width and a grid larger than the store.
        cfg_write(REG_ORIGIN_X, -32'sd65536);
        cfg_write(REG_CELLS_PER_METRE, 32'd65536);
        cfg_write(REG_GRID_WIDTH, 32'd8191);
        cfg_write(REG_GRID_HEIGHT, 32'd4096);
        cfg_write(REG_FREE_THRESHOLD, 32'hffff_ff80);
        cfg_ch.valid <= 1'b0;
        send_write(20'hfffff, 8'sd5);
        send_cell(4095 * 256 + 128, 255 * 256 + 128);
        send_cell(4095 * 256, 256 * 256);
        send_cell(4096 * 256, 0);

        for (int k = 0; k < PHASES; k++) begin
            wait_drained();
            configure_phase(k);
            calm = (k == CALM_PHASE);
            repeat (WORDS_PER_PHASE) begin
                if ($urandom_range(99) < 20) send_random_write();
                else send_random_point();
            end
        end
        calm = 1'b0;
        wait_drained();

        if (scoreboard.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/ogpf_pkg.sv
src/ogpf_if.sv
src/ogpf_cfg_regs.sv
src/ogpf_cell_calc.sv
src/ogpf_grid_map.sv
src/occupancy_grid_point_filter_core.sv
src/ogpf_checker.sv
tb/sv/tb_top.sv
